### rtl/core/keyword_token_scanner_core_assert.svh
// Assertion helpers for the scanner core. The enclosing scope must provide
// clk and rst.
`ifndef KEYWORD_TOKEN_SCANNER_CORE_ASSERT_SVH
`define KEYWORD_TOKEN_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KTS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define KTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner check failed: next-cycle implication");

`endif

### rtl/core/kts_pkg.sv
package kts_pkg;

  // Field widths.
  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 12;
  localparam int LENGTH_BITS = 8;
  localparam int KIND_BITS   = 5;
  localparam int KW_COUNT    = 11;
  localparam int KW_SLOTS    = 8;

  // Queue between the classifier and the emitter.
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef logic [KIND_BITS-1:0] kind_t;

  // Token kinds.
  localparam kind_t KIND_EOF    = 5'd0;
  localparam kind_t KIND_IDENT  = 5'd1;
  localparam kind_t KIND_NUMBER = 5'd2;
  localparam kind_t KIND_STRING = 5'd3;
  localparam kind_t KIND_ERROR  = 5'd4;
  localparam kind_t KIND_ARROW  = 5'd5;
  localparam kind_t KIND_MINUS  = 5'd6;
  localparam kind_t KIND_KW0    = 5'd7;
  localparam kind_t KIND_SINGLE = 5'd18;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_QUOTE      = 8'd34;
  localparam logic [7:0] CH_HASH       = 8'd35;
  localparam logic [7:0] CH_MINUS      = 8'd45;
  localparam logic [7:0] CH_DOT        = 8'd46;
  localparam logic [7:0] CH_GT         = 8'd62;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;

  // Keyword spellings, one byte per slot, and their lengths.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
    '{"l", "e", "t", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"m", "u", "t", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"f", "n", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"r", "e", "t", "u", "r", "n", 8'd0, 8'd0},
    '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"e", "l", "s", "e", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"m", "a", "t", "c", "h", 8'd0, 8'd0, 8'd0},
    '{"f", "o", "r", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"w", "h", "i", "l", "e", 8'd0, 8'd0, 8'd0},
    '{"a", "s", "y", "n", "c", 8'd0, 8'd0, 8'd0},
    '{"a", "w", "a", "i", "t", 8'd0, 8'd0, 8'd0}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd3, 3'd2, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd5, 3'd5, 3'd5
  };

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             ch;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [LENGTH_BITS-1:0] len;
  } token_t;

  // All tokens caused by one input byte; tok_b is used only when two is set.
  typedef struct packed {
    logic   two;
    token_t tok_a;
    token_t tok_b;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Drops every keyword that does not have byte c at position pos.
  function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] cand,
                                                    input logic [LENGTH_BITS-1:0] pos,
                                                    input logic [7:0] c);
    logic [KW_COUNT-1:0] keep;
    keep = cand;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (pos >= LENGTH_BITS'(KW_LEN[k]) || KW_TEXT[k][pos[2:0]] != c) begin
        keep[k] = 1'b0;
      end
    end
    return keep;
  endfunction

  // Kind of a finished identifier: a keyword whose spelling survived and whose
  // length equals the identifier length, else a plain identifier.
  function automatic kind_t ident_kind(input logic [KW_COUNT-1:0] cand,
                                       input logic [LENGTH_BITS-1:0] len);
    kind_t kind;
    kind = KIND_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && len == LENGTH_BITS'(KW_LEN[k])) begin
        kind = KIND_KW0 + kind_t'(k);
      end
    end
    return kind;
  endfunction

endpackage

### rtl/core/kts_in_if.sv
interface kts_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;

  modport source (output valid, output action, output char_code, input ready);
  modport sink (input valid, input action, input char_code, output ready);
endinterface

### rtl/core/kts_out_if.sv
interface kts_out_if;
  logic                            valid;
  logic                            ready;
  kts_pkg::kind_t                  token_kind;
  logic [7:0]                      token_char;
  logic [kts_pkg::LINE_BITS-1:0]   start_line;
  logic [kts_pkg::COLUMN_BITS-1:0] start_column;
  logic [kts_pkg::LENGTH_BITS-1:0] token_length;
  logic                            last;

  modport source (output valid, output token_kind, output token_char, output start_line,
                  output start_column, output token_length, output last, input ready);
  modport sink (input valid, input token_kind, input token_char, input start_line,
                input start_column, input token_length, input last, output ready);
endinterface

### rtl/core/kts_front.sv
module kts_front (
  input  logic                   clk,
  input  logic                   rst,
  kts_in_if.sink                 chars,
  input  kts_pkg::queue_status_t q_status,
  output logic                   push,
  output kts_pkg::bundle_t       push_data
);

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_IDENT   = 6'b000010,
    M_NUMBER  = 6'b000100,
    M_STRING  = 6'b001000,
    M_COMMENT = 6'b010000,
    M_MINUS   = 6'b100000
  } mode_t;

  localparam logic [kts_pkg::COLUMN_BITS-1:0] COL_MAX = '1;
  localparam logic [kts_pkg::LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [kts_pkg::LENGTH_BITS-1:0] LEN_ONE = kts_pkg::LENGTH_BITS'(1);
  localparam logic [kts_pkg::LENGTH_BITS-1:0] LEN_TWO = kts_pkg::LENGTH_BITS'(2);
  localparam logic [kts_pkg::KW_COUNT-1:0]    CAND_ALL = '1;

  mode_t                           mode, mode_next;
  logic [kts_pkg::KW_COUNT-1:0]    cand, cand_next;
  logic [kts_pkg::LINE_BITS-1:0]   line_count, line_next;
  logic [kts_pkg::COLUMN_BITS-1:0] column_count, column_next;
  logic [kts_pkg::LINE_BITS-1:0]   start_line, start_line_next;
  logic [kts_pkg::COLUMN_BITS-1:0] start_column, start_column_next;
  logic [kts_pkg::LENGTH_BITS-1:0] length_count, length_next;
  logic                            finished, finished_next;

  logic                            accept;
  logic [7:0]                      c;
  logic [kts_pkg::LENGTH_BITS-1:0] len_sat;
  logic                            fall;
  logic                            pend_valid, tail_valid;
  kts_pkg::token_t                 pend_tok, tail_tok;

  function automatic logic is_space(input logic [7:0] b);
    return b == kts_pkg::CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction

  assign chars.ready = !q_status.full;
  assign accept      = chars.valid && chars.ready;
  assign c           = chars.char_code;
  assign len_sat     = (length_count != LEN_MAX) ? length_count + LEN_ONE : length_count;

  // One scanner step: the pending token that this byte closes, and the token
  // or state that the byte itself starts.
  always_comb begin
    mode_next         = mode;
    cand_next         = cand;
    line_next         = line_count;
    column_next       = column_count;
    start_line_next   = start_line;
    start_column_next = start_column;
    length_next       = length_count;
    finished_next     = finished;
    fall              = 1'b0;
    pend_valid        = 1'b0;
    tail_valid        = 1'b0;
    pend_tok          = '{kind: kts_pkg::KIND_EOF, ch: 8'd0, line: start_line,
                          col: start_column, len: length_count};
    tail_tok          = '{kind: kts_pkg::KIND_EOF, ch: 8'd0, line: line_count,
                          col: column_count, len: '0};

    if (finished) begin
      tail_valid = 1'b1;
    end else if (chars.action) begin
      // End of input: flush what is pending, then end-of-file.
      unique case (mode)
        M_IDENT: begin
          pend_valid    = 1'b1;
          pend_tok.kind = kts_pkg::ident_kind(cand, length_count);
        end
        M_NUMBER: begin
          pend_valid    = 1'b1;
          pend_tok.kind = kts_pkg::KIND_NUMBER;
        end
        M_STRING: begin
          pend_valid    = 1'b1;
          pend_tok.kind = kts_pkg::KIND_ERROR;
        end
        M_MINUS: begin
          pend_valid    = 1'b1;
          pend_tok.kind = kts_pkg::KIND_MINUS;
        end
        default: begin
          pend_valid = 1'b0;
        end
      endcase
      tail_valid    = 1'b1;
      mode_next     = M_IDLE;
      finished_next = 1'b1;
    end else begin
      // Position update for the byte.
      column_next = (column_count != COL_MAX) ? column_count + 1'b1 : column_count;
      if (c == kts_pkg::CH_LF) begin
        line_next   = line_count + 1'b1;
        column_next = '0;
      end

      unique case (mode)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == kts_pkg::CH_UNDERSCORE) begin
            cand_next   = kts_pkg::kw_filter(cand, length_count, c);
            length_next = len_sat;
          end else begin
            pend_valid    = 1'b1;
            pend_tok.kind = kts_pkg::ident_kind(cand, length_count);
            fall          = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c) || c == kts_pkg::CH_DOT) begin
            length_next = len_sat;
          end else begin
            pend_valid    = 1'b1;
            pend_tok.kind = kts_pkg::KIND_NUMBER;
            fall          = 1'b1;
          end
        end
        M_STRING: begin
          if (c == kts_pkg::CH_QUOTE) begin
            pend_valid    = 1'b1;
            pend_tok.kind = kts_pkg::KIND_STRING;
            mode_next     = M_IDLE;
          end else begin
            length_next = len_sat;
          end
        end
        M_COMMENT: begin
          if (c == kts_pkg::CH_LF || c == kts_pkg::CH_CR) begin
            mode_next = M_IDLE;
          end
        end
        M_MINUS: begin
          pend_valid = 1'b1;
          if (c == kts_pkg::CH_GT) begin
            pend_tok.kind = kts_pkg::KIND_ARROW;
            pend_tok.len  = LEN_TWO;
            length_next   = LEN_TWO;
            mode_next     = M_IDLE;
          end else begin
            pend_tok.kind = kts_pkg::KIND_MINUS;
            fall          = 1'b1;
          end
        end
        default: begin
          fall = 1'b1;
        end
      endcase

      // The byte starts something new from the idle state.
      if (fall) begin
        mode_next = M_IDLE;
        if (is_space(c)) begin
          mode_next = M_IDLE;
        end else if (is_alpha(c)) begin
          mode_next         = M_IDENT;
          start_line_next   = line_next;
          start_column_next = column_next;
          length_next       = LEN_ONE;
          cand_next         = kts_pkg::kw_filter(CAND_ALL, '0, c);
        end else if (is_digit(c) || c == kts_pkg::CH_DOT) begin
          mode_next         = M_NUMBER;
          start_line_next   = line_next;
          start_column_next = column_next;
          length_next       = LEN_ONE;
        end else if (c == kts_pkg::CH_QUOTE) begin
          mode_next         = M_STRING;
          start_line_next   = line_next;
          start_column_next = column_next;
          length_next       = '0;
        end else if (c == kts_pkg::CH_HASH) begin
          mode_next = M_COMMENT;
        end else if (c == kts_pkg::CH_MINUS) begin
          mode_next         = M_MINUS;
          start_line_next   = line_next;
          start_column_next = column_next;
          length_next       = LEN_ONE;
        end else begin
          tail_valid = 1'b1;
          tail_tok   = '{kind: kts_pkg::KIND_SINGLE, ch: c, line: line_next,
                         col: column_next, len: LEN_ONE};
        end
      end
    end
  end

  // Pack the step's tokens into one queue entry.
  always_comb begin
    push_data.two   = pend_valid && tail_valid;
    push_data.tok_a = pend_valid ? pend_tok : tail_tok;
    push_data.tok_b = tail_tok;
    push            = accept && (pend_valid || tail_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      cand         <= CAND_ALL;
      line_count   <= kts_pkg::LINE_BITS'(1);
      column_count <= '0;
      start_line   <= '0;
      start_column <= '0;
      length_count <= '0;
      finished     <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      cand         <= cand_next;
      line_count   <= line_next;
      column_count <= column_next;
      start_line   <= start_line_next;
      start_column <= start_column_next;
      length_count <= length_next;
      finished     <= finished_next;
    end
  end

endmodule

### rtl/core/kts_queue.sv
module kts_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  kts_pkg::bundle_t       push_data,
  input  logic                   pop,
  output kts_pkg::bundle_t       head,
  output kts_pkg::queue_status_t status
);

  localparam logic [kts_pkg::QUEUE_PTR_BITS:0] COUNT_FULL =
    (kts_pkg::QUEUE_PTR_BITS + 1)'(kts_pkg::QUEUE_DEPTH);

  kts_pkg::bundle_t                    entries [kts_pkg::QUEUE_DEPTH];
  logic [kts_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [kts_pkg::QUEUE_PTR_BITS:0]    count;
  logic                                do_push, do_pop;

  assign status.full  = count == COUNT_FULL;
  assign status.empty = count == '0;
  assign head         = entries[rd_ptr];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/kts_back.sv
module kts_back (
  input  logic                   clk,
  input  logic                   rst,
  input  kts_pkg::bundle_t       head,
  input  kts_pkg::queue_status_t q_status,
  output logic                   pop,
  kts_out_if.source              tokens
);

  logic            sub;
  logic            xfer;
  kts_pkg::token_t tok;

  // Present the head entry one token at a time.
  assign tok                 = sub ? head.tok_b : head.tok_a;
  assign tokens.valid        = !q_status.empty;
  assign tokens.token_kind   = tok.kind;
  assign tokens.token_char   = tok.ch;
  assign tokens.start_line   = tok.line;
  assign tokens.start_column = tok.col;
  assign tokens.token_length = tok.len;
  assign tokens.last         = sub || !head.two;

  assign xfer = tokens.valid && tokens.ready;
  assign pop  = xfer && tokens.last;

  // Token select within a two-token entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (xfer) begin
      sub <= !tokens.last;
    end
  end

endmodule

### rtl/core/keyword_token_scanner_core.sv
// Channel   Direction  Transfer carries
// chars     in         action, char_code
// tokens    out        token_kind, token_char, start_line, start_column,
//                      token_length, last
//
// One byte is accepted per cycle while the token queue has room; the queue
// holds four entries of up to two tokens each.
// The emitter drains one token per cycle while tokens.ready is high, so a
// byte that closes one token and makes another gives two tokens; the queue
// absorbs such bursts. A byte's tokens reach the output from a registered queue entry.
// Reset is synchronous and clears the scanner state and the queue at once.
// A stall on tokens fills the queue and then holds chars.ready low.
`include "keyword_token_scanner_core_assert.svh"

module keyword_token_scanner_core (
  input  logic       clk,
  input  logic       rst,
  kts_in_if.sink     chars,
  kts_out_if.source  tokens
);

  kts_pkg::queue_status_t q_status;
  kts_pkg::bundle_t       push_data;
  kts_pkg::bundle_t       head;
  logic                   push;
  logic                   pop;

  // Classifier: one byte per transfer into token bundles.
  kts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  kts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Emitter: one token per transfer.
  kts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .tokens   (tokens)
  );

  // End-of-file always closes its group.
  `KTS_ASSERT_IMPLIES(a_eof_is_last, tokens.valid && tokens.token_kind == kts_pkg::KIND_EOF,
                      tokens.last)

  // Only a flushed pending token can lead a two-token group.
  `KTS_ASSERT_IMPLIES(a_lead_is_pending, tokens.valid && !tokens.last,
                      tokens.token_kind != kts_pkg::KIND_SINGLE &&
                      tokens.token_kind != kts_pkg::KIND_ARROW &&
                      tokens.token_kind != kts_pkg::KIND_STRING)

  // The second token of a group follows right after the first.
  `KTS_ASSERT_NEXT(a_second_follows, tokens.valid && tokens.ready && !tokens.last,
                   tokens.valid && tokens.last)

endmodule
